// ----- sv/pat_pkg.sv -----
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants of the periodic alarm table: command and status
// codes, the slot record held in the slot memory, and reset values.
// ----------------------------------------------------------------------------
package pat_pkg;

  // Field widths of the stream and configuration ports
  localparam int unsigned CFG_W      = 30;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned CNT_OUT_W  = 7;
  localparam int unsigned NS_W       = 64;
  localparam int unsigned S_DATA_W   = 64;
  localparam int unsigned S_USER_W   = 2;
  localparam int unsigned M_DATA_W   = 136;
  localparam int unsigned M_USER_W   = 3;

  // Defaults
  localparam int unsigned NUM_SLOTS_DEF   = 16;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam logic [CFG_W-1:0] NS_PER_TICK_RST = CFG_W'(1000000);

  // Command carried in the input tuser
  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_CREATE  = 2'd1,
    MODE_DESTROY = 2'd2
  } mode_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_INTV = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // One alarm slot as stored in the slot memory
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] period;
    logic [ID_W-1:0] remaining;
  } slot_t;

endpackage

// ----- sv/pat_ram.sv -----
// ----------------------------------------------------------------------------
// pat_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// The read register holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module pat_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/periodic_alarm_table.sv -----
// ----------------------------------------------------------------------------
// periodic_alarm_table
// Table of alarm slots driven by tick, create and destroy commands. A tick
// counts time and walks all slots, reporting expiring slots up to MAX_RESULTS.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+---------------------------------
//  s_axis    | in  | tvalid / tready         | tdata: interval, target id;
//            |     |                         | tuser: command
//  m_axis    | out | tvalid / tready / tlast | tdata: id, count, ticks, ns;
//            |     |                         | tuser: fired, status
//  cfg       | in  | cfg_we_i                | ns_per_tick
//
//  A tick walks one slot per cycle, unless the output stalls, through the
//  single read port of the slot memory and one shared decrement / compare
//  unit. Create stops at the first free slot, destroy at the first matching
//  slot; an unknown command or a zero interval skips the walk.
//  The block takes a new item only after the last result of the previous
//  one sits in the output register. No clearing pass after reset: slot
//  valid bits are flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module periodic_alarm_table #(
  parameter int unsigned NUM_SLOTS = pat_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [pat_pkg::CFG_W-1:0]      cfg_wdata_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] interval_ticks, [63:32] target_id
  input  logic [pat_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // [1:0] mode
  input  logic [pat_pkg::S_USER_W-1:0]   s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] alarm_id, [38:32] active_count, [70:39] tick_count,
  // [134:71] elapsed_ns, [135] zero
  output logic [pat_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // [0] fired, [2:1] status
  output logic [pat_pkg::M_USER_W-1:0]   m_axis_tuser,
  output logic                           m_axis_tlast
);

  import pat_pkg::*;

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned REP_W = $clog2(MAX_RESULTS + 1);
  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

  state_e               state_q;
  logic [CFG_W-1:0]     ns_per_tick_q;
  logic [NUM_SLOTS-1:0] active_q;
  logic [ID_W-1:0]      next_id_q;
  logic [CNT_W-1:0]     count_q;
  logic [ID_W-1:0]      ticks_q;
  logic [NS_W-1:0]      ns_q;

  // latched command
  logic [1:0]           mode_q;
  logic [ID_W-1:0]      interval_q;
  logic [ID_W-1:0]      target_q;

  // walk pipeline: read stage and evaluate stage
  logic [CNT_W-1:0]     rd_idx_q;
  logic                 ev_valid_q;
  logic [IDX_W-1:0]     ev_idx_q;

  // pending fired id and final result
  logic                 pend_valid_q;
  logic [ID_W-1:0]      pend_id_q;
  logic [REP_W-1:0]     nrep_q;
  logic [ID_W-1:0]      fin_id_q;
  status_e              fin_status_q;

  // output register
  logic                 m_valid_q;
  logic [M_DATA_W-1:0]  m_data_q;
  logic [M_USER_W-1:0]  m_user_q;
  logic                 m_last_q;

  // slot memory
  logic                 ram_we;
  logic                 ram_re;
  logic [SLOT_W-1:0]    ram_rdata;
  slot_t                ev_slot;
  slot_t                wr_slot;

  logic                 is_tick, is_create, is_destroy;
  logic [ID_W-1:0]      dec;
  logic [ID_W-1:0]      cmp_a, cmp_b;
  logic                 cmp_eq;
  logic                 ev_act;
  logic                 fire;
  logic                 report;
  logic                 out_free;
  logic                 stall;
  logic                 push_walk;
  logic                 push_fin;
  logic                 s_accept;
  logic                 walk_done;

  assign is_tick    = (mode_q == MODE_TICK);
  assign is_create  = (mode_q == MODE_CREATE);
  assign is_destroy = (mode_q == MODE_DESTROY);

  // Shared unit: one decrement and one 32-bit equality compare
  assign ev_slot = slot_t'(ram_rdata);
  assign dec     = ev_slot.remaining - ID_W'(1);
  assign cmp_a   = is_tick ? dec : ev_slot.id;
  assign cmp_b   = is_tick ? '0 : target_q;
  assign cmp_eq  = (cmp_a == cmp_b);
  assign ev_act  = active_q[ev_idx_q];

  assign fire    = ev_valid_q && is_tick && ev_act && cmp_eq;
  assign report  = fire && (nrep_q < REP_W'(MAX_RESULTS));

  // Output handshake
  assign out_free  = !m_valid_q || m_axis_tready;
  assign stall     = (state_q == ST_WALK) && report && pend_valid_q && !out_free;
  assign push_walk = (state_q == ST_WALK) && report && pend_valid_q && out_free;
  assign push_fin  = (state_q == ST_FIN) && out_free;
  assign walk_done = !ev_valid_q && (rd_idx_q == CNT_W'(NUM_SLOTS));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Memory access: read ahead by one slot, write back the evaluated slot
  assign ram_re = (state_q == ST_WALK) && !stall && (rd_idx_q < CNT_W'(NUM_SLOTS));
  assign ram_we = (state_q == ST_WALK) && ev_valid_q && !stall &&
                  ((is_tick && ev_act) || (is_create && !ev_act));

  always_comb begin
    if (is_create) begin
      wr_slot.id        = next_id_q;
      wr_slot.period    = interval_q;
      wr_slot.remaining = interval_q;
    end else begin
      wr_slot.id        = ev_slot.id;
      wr_slot.period    = ev_slot.period;
      wr_slot.remaining = cmp_eq ? ev_slot.period : dec;
    end
  end

  pat_ram #(
    .Width (SLOT_W),
    .Depth (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ev_idx_q),
    .wdata_i (wr_slot),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ns_per_tick_q <= NS_PER_TICK_RST;
      active_q      <= '0;
      next_id_q     <= ID_W'(1);
      count_q       <= '0;
      ticks_q       <= '0;
      ns_q          <= '0;
      mode_q        <= '0;
      interval_q    <= '0;
      target_q      <= '0;
      rd_idx_q      <= '0;
      ev_valid_q    <= 1'b0;
      ev_idx_q      <= '0;
      pend_valid_q  <= 1'b0;
      pend_id_q     <= '0;
      nrep_q        <= '0;
      fin_id_q      <= '0;
      fin_status_q  <= ST_OK;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      m_user_q      <= '0;
      m_last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ns_per_tick_q <= cfg_wdata_i;
      end

      // drop the output item once taken, unless a new one replaces it
      if (m_axis_tready && !push_walk && !push_fin) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            mode_q       <= s_axis_tuser;
            interval_q   <= s_axis_tdata[31:0];
            target_q     <= s_axis_tdata[63:32];
            rd_idx_q     <= '0;
            ev_valid_q   <= 1'b0;
            pend_valid_q <= 1'b0;
            nrep_q       <= '0;
            fin_id_q     <= '0;
            fin_status_q <= ST_OK;
            case (s_axis_tuser)
              MODE_TICK: begin
                ticks_q <= ticks_q + ID_W'(1);
                ns_q    <= ns_q + NS_W'(ns_per_tick_q);
                state_q <= ST_WALK;
              end
              MODE_CREATE: begin
                if (s_axis_tdata[31:0] == '0) begin
                  fin_status_q <= ST_ZERO_INTV;
                  state_q      <= ST_FIN;
                end else begin
                  state_q <= ST_WALK;
                end
              end
              MODE_DESTROY: begin
                state_q <= ST_WALK;
              end
              default: begin
                state_q <= ST_FIN;
              end
            endcase
          end
        end

        ST_WALK: begin
          if (!stall) begin
            // advance the read stage
            if (ram_re) begin
              rd_idx_q   <= rd_idx_q + CNT_W'(1);
              ev_valid_q <= 1'b1;
              ev_idx_q   <= rd_idx_q[IDX_W-1:0];
            end else begin
              ev_valid_q <= 1'b0;
            end

            if (ev_valid_q) begin
              if (is_tick && report) begin
                // hold the newest fired id; the older one goes out now
                pend_valid_q <= 1'b1;
                pend_id_q    <= ev_slot.id;
                nrep_q       <= nrep_q + REP_W'(1);
                if (pend_valid_q) begin
                  m_valid_q <= 1'b1;
                  m_data_q  <= {1'b0, ns_q, ticks_q, CNT_OUT_W'(count_q), pend_id_q};
                  m_user_q  <= {ST_OK, 1'b1};
                  m_last_q  <= 1'b0;
                end
              end else if (is_create && !ev_act) begin
                active_q[ev_idx_q] <= 1'b1;
                count_q            <= count_q + CNT_W'(1);
                next_id_q          <= next_id_q + ID_W'(1);
                fin_id_q           <= next_id_q;
                state_q            <= ST_FIN;
              end else if (is_destroy && ev_act && cmp_eq) begin
                active_q[ev_idx_q] <= 1'b0;
                count_q            <= count_q - CNT_W'(1);
                fin_id_q           <= target_q;
                state_q            <= ST_FIN;
              end
            end else if (walk_done) begin
              if (is_create) begin
                fin_status_q <= ST_FULL;
              end else if (is_destroy) begin
                fin_status_q <= ST_NOT_FOUND;
              end
              state_q <= ST_FIN;
            end
          end
        end

        ST_FIN: begin
          // emit the closing item of this command
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {1'b0, ns_q, ticks_q, CNT_OUT_W'(count_q),
                          pend_valid_q ? pend_id_q : fin_id_q};
            m_user_q  <= {fin_status_q, pend_valid_q};
            m_last_q  <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  // active count always matches the slot valid bits
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNT_W'($countones(active_q)))
    else $error("active count out of step with slot valid bits");

  // never overwrite an output item that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_walk || push_fin) |-> out_free)
    else $error("output item overwritten");

  // reported fired items stay within the result limit
  a_rep_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrep_q <= REP_W'(MAX_RESULTS))
    else $error("too many fired items reported");

  // memory is written only while walking on an evaluated slot
  a_we_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_WALK) && ev_valid_q))
    else $error("slot memory written outside a walk");

  // an accepted item always leaves idle on the next cycle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q != ST_IDLE))
    else $error("accepted item did not start");
`endif

endmodule

// ----- sim/tb_periodic_alarm_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_alarm_table
// Self-checking bench for the periodic alarm table. A short command table
// covers reset values, every status code, extreme intervals and a full
// table expiring in one tick. Random command mixes then run under several
// tick lengths. Every report on the output stream is checked field by field
// against an untimed model of the table, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_periodic_alarm_table;
  import pat_pkg::*;

  localparam int unsigned SLOTS       = NUM_SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = NUM_SLOTS_DEF + 8;
  localparam int unsigned IDLE_PCT    = 34;
  localparam int unsigned MAX_SHOWN   = 10;
  // command code the block treats as a no-op
  localparam logic [1:0]  MODE_UNDEF  = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]      alarm_id;
    logic                 fired;
    status_e              status;
    logic [CNT_OUT_W-1:0] active_count;
    logic [31:0]          tick_count;
    logic [NS_W-1:0]      elapsed_ns;
    logic                 last;
  } alarm_report_t;

  typedef struct {
    logic [1:0]    op;
    logic [31:0]   interval;
    logic [31:0]   target;
    int            reps;
    bit            known;
    alarm_report_t want;
  } plan_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [S_USER_W-1:0] s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [M_USER_W-1:0] m_axis_tuser;
  logic                m_axis_tlast;

  // Alarm table model state
  logic [CFG_W-1:0]     ns_step;
  logic                 slot_on     [SLOTS];
  logic [ID_W-1:0]      slot_tag    [SLOTS];
  logic [ID_W-1:0]      slot_reload [SLOTS];
  logic [ID_W-1:0]      slot_left   [SLOTS];
  logic [ID_W-1:0]      id_next;
  logic [CNT_OUT_W-1:0] live_count;
  logic [31:0]          tick_total;
  logic [NS_W-1:0]      ns_sum;

  alarm_report_t pending_reports[$];

  bit calm         = 1'b0;
  int issued       = 0;
  int checked      = 0;
  int expiries     = 0;
  int full_rejects = 0;
  int settings     = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  periodic_alarm_table #(
    .NUM_SLOTS(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Append one expected report carrying the post-command counters
  function automatic void queue_report(logic [ID_W-1:0] id, logic fire, status_e st,
                                       logic fin);
    alarm_report_t rep;
    rep = '{alarm_id: id, fired: fire, status: st, active_count: live_count,
            tick_count: tick_total, elapsed_ns: ns_sum, last: fin};
    pending_reports.push_back(rep);
  endfunction

  // Apply one accepted command to the model; return the number of reports
  function automatic int model_command(logic [1:0] op, logic [31:0] intv,
                                       logic [31:0] tgt);
    logic [ID_W-1:0] fired_tags[$];
    int              hit;
    hit = -1;
    case (op)
      MODE_TICK: begin
        tick_total = tick_total + 1'b1;
        ns_sum     = ns_sum + NS_W'(ns_step);
        // walk the slots in order, count down and reload on expiry
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_on[i]) begin
            slot_left[i] = slot_left[i] - 1'b1;
            if (slot_left[i] == '0) begin
              if (fired_tags.size() < MAX_RESULTS) fired_tags.push_back(slot_tag[i]);
              if (slot_reload[i] != '0) begin
                slot_left[i] = slot_reload[i];
              end else begin
                slot_on[i] = 1'b0;
                live_count = live_count - 1'b1;
              end
            end
          end
        end
        if (fired_tags.size() == 0) begin
          queue_report('0, 1'b0, ST_OK, 1'b1);
          return 1;
        end
        foreach (fired_tags[k]) begin
          queue_report(fired_tags[k], 1'b1, ST_OK, k == fired_tags.size() - 1);
        end
        return fired_tags.size();
      end
      MODE_CREATE: begin
        if (intv == '0) begin
          queue_report('0, 1'b0, ST_ZERO_INTV, 1'b1);
          return 1;
        end
        for (int i = 0; i < SLOTS && hit < 0; i++) begin
          if (!slot_on[i]) hit = i;
        end
        if (hit < 0) begin
          full_rejects++;
          queue_report('0, 1'b0, ST_FULL, 1'b1);
          return 1;
        end
        // claim the lowest free slot with the next id
        slot_on[hit]     = 1'b1;
        slot_tag[hit]    = id_next;
        slot_reload[hit] = intv;
        slot_left[hit]   = intv;
        id_next          = id_next + 1'b1;
        live_count       = live_count + 1'b1;
        queue_report(slot_tag[hit], 1'b0, ST_OK, 1'b1);
        return 1;
      end
      MODE_DESTROY: begin
        for (int i = 0; i < SLOTS && hit < 0; i++) begin
          if (slot_on[i] && slot_tag[i] == tgt) hit = i;
        end
        if (hit < 0) begin
          queue_report('0, 1'b0, ST_NOT_FOUND, 1'b1);
        end else begin
          slot_on[hit] = 1'b0;
          live_count   = live_count - 1'b1;
          queue_report(tgt, 1'b0, ST_OK, 1'b1);
        end
        return 1;
      end
      default: begin
        queue_report('0, 1'b0, ST_OK, 1'b1);
        return 1;
      end
    endcase
  endfunction

  // Expected single report of a simple command at the reset tick length
  function automatic alarm_report_t report_at(logic [ID_W-1:0] id, status_e st,
                                              logic [CNT_OUT_W-1:0] cnt,
                                              logic [31:0] ticks);
    report_at = '{alarm_id: id, fired: 1'b0, status: st, active_count: cnt,
                  tick_count: ticks, elapsed_ns: NS_W'(ticks) * NS_W'(NS_PER_TICK_RST),
                  last: 1'b1};
  endfunction

  function automatic bit roll_idle();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic issue_command(input logic [1:0] op, input logic [31:0] intv,
                               input logic [31:0] tgt, output int made);
    while (roll_idle()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tgt, intv};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    made = model_command(op, intv, tgt);
    issued++;
  endtask

  // Drop valid and wait until every report is in, plus the block's walk time
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_ns_step(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ns_step = value;
    settings++;
  endtask

  task automatic run_random_phase(input int count, input int tick_pct, input int create_pct);
    logic [1:0]      op;
    logic [31:0]     intv;
    logic [31:0]     tgt;
    logic [ID_W-1:0] live_tags[$];
    int              roll;
    int              made;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      intv = $urandom;
      tgt  = $urandom;
      if (roll < tick_pct) begin
        op = MODE_TICK;
      end else if (roll < tick_pct + create_pct) begin
        // mostly short periods so alarms expire often
        op   = MODE_CREATE;
        roll = $urandom_range(0, 99);
        if (roll < 80) intv = $urandom_range(1, 6);
        else if (roll < 90) intv = '0;
      end else if (roll < 95) begin
        // mostly live ids, some never issued, some random
        op = MODE_DESTROY;
        live_tags.delete();
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_on[i]) live_tags.push_back(slot_tag[i]);
        end
        roll = $urandom_range(0, 99);
        if (live_tags.size() != 0 && roll < 75) begin
          tgt = live_tags[$urandom_range(0, live_tags.size() - 1)];
        end else if (roll < 85) begin
          tgt = id_next;
        end
      end else begin
        op = MODE_UNDEF;
      end
      issue_command(op, intv, tgt, made);
    end
  endtask

  // Stimulus: reset, command table, then random phases per tick length
  initial begin : stimulus
    plan_row_t directed_plan[$];
    int        made;

    ns_step    = NS_PER_TICK_RST;
    id_next    = 32'd1;
    live_count = '0;
    tick_total = '0;
    ns_sum     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_on[i]     = 1'b0;
      slot_tag[i]    = '0;
      slot_reload[i] = '0;
      slot_left[i]   = '0;
    end

    directed_plan.push_back('{MODE_TICK, 32'd0, 32'd0, 1, 1'b1,
                              report_at('0, ST_OK, 7'd0, 32'd1)});
    directed_plan.push_back('{MODE_DESTROY, 32'd0, 32'hFFFF_FFFF, 1, 1'b1,
                              report_at('0, ST_NOT_FOUND, 7'd0, 32'd1)});
    directed_plan.push_back('{MODE_CREATE, 32'd0, 32'd0, 1, 1'b1,
                              report_at('0, ST_ZERO_INTV, 7'd0, 32'd1)});
    directed_plan.push_back('{MODE_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1,
                              report_at('0, ST_OK, 7'd0, 32'd1)});
    directed_plan.push_back('{MODE_CREATE, 32'd1, 32'd0, 1, 1'b1,
                              report_at(32'd1, ST_OK, 7'd1, 32'd1)});
    directed_plan.push_back('{MODE_CREATE, 32'hFFFF_FFFF, 32'd0, 1, 1'b1,
                              report_at(32'd2, ST_OK, 7'd2, 32'd1)});
    directed_plan.push_back('{MODE_DESTROY, 32'd0, 32'd2, 1, 1'b1,
                              report_at(32'd2, ST_OK, 7'd1, 32'd1)});
    // fill the table with one-tick alarms
    directed_plan.push_back('{MODE_CREATE, 32'd1, 32'd0, 15, 1'b0, '0});
    directed_plan.push_back('{MODE_CREATE, 32'd3, 32'd0, 1, 1'b1,
                              report_at('0, ST_FULL, 7'd16, 32'd1)});
    // every slot expires on this tick
    directed_plan.push_back('{MODE_TICK, 32'd0, 32'd0, 1, 1'b0, '0});
    directed_plan.push_back('{MODE_DESTROY, 32'd0, 32'd1, 1, 1'b1,
                              report_at(32'd1, ST_OK, 7'd15, 32'd2)});
    directed_plan.push_back('{MODE_DESTROY, 32'd0, 32'd0, 1, 1'b1,
                              report_at('0, ST_NOT_FOUND, 7'd15, 32'd2)});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // walk the command table; known rows replace the model's report
    foreach (directed_plan[r]) begin
      for (int k = 0; k < directed_plan[r].reps; k++) begin
        issue_command(directed_plan[r].op, directed_plan[r].interval,
                      directed_plan[r].target, made);
        if (directed_plan[r].known) begin
          repeat (made) void'(pending_reports.pop_back());
          pending_reports.push_back(directed_plan[r].want);
        end
      end
    end

    set_ns_step(CFG_W'(1));
    run_random_phase(21, 40, 30);
    set_ns_step(CFG_W'(1000000000));
    calm = 1'b1;
    run_random_phase(21, 35, 40);
    calm = 1'b0;
    set_ns_step('0);
    run_random_phase(21, 45, 25);
    set_ns_step(CFG_W'($urandom_range(1, 1000000000)));
    run_random_phase(21, 40, 30);

    wait_idle();
    $display("%0d commands issued, %0d reports checked, %0d expiries, %0d full-table rejects",
             issued, checked, expiries, full_rejects);
    $display("%0d tick-length settings, %0d mismatches", settings, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Random backpressure on the report stream
  always @(posedge clk_i) begin : drive_ready
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each accepted report with the oldest expectation
  always @(posedge clk_i) begin : check_reports
    alarm_report_t got;
    alarm_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.alarm_id     = m_axis_tdata[31:0];
      got.active_count = m_axis_tdata[38:32];
      got.tick_count   = m_axis_tdata[70:39];
      got.elapsed_ns   = m_axis_tdata[134:71];
      got.fired        = m_axis_tuser[0];
      got.status       = status_e'(m_axis_tuser[2:1]);
      got.last         = m_axis_tlast;
      checked++;
      if (got.fired === 1'b1) expiries++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("%0t: unexpected report id %0d fired %0d status %0d", $realtime,
                   got.alarm_id, got.fired, got.status);
        end
      end else begin
        want = pending_reports.pop_front();
        if (got.alarm_id !== want.alarm_id || got.fired !== want.fired ||
            got.status !== want.status || got.active_count !== want.active_count ||
            got.tick_count !== want.tick_count || got.elapsed_ns !== want.elapsed_ns ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t: report mismatch (id fired status count ticks ns last)", $realtime);
            $display("  expected %0d %0d %0d %0d %0d %0d %0d", want.alarm_id, want.fired,
                     want.status, want.active_count, want.tick_count, want.elapsed_ns,
                     want.last);
            $display("  actual   %0d %0d %0d %0d %0d %0d %0d", got.alarm_id, got.fired,
                     got.status, got.active_count, got.tick_count, got.elapsed_ns,
                     got.last);
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               pending_reports.size());
      $display("status: fail");
      $finish;
    end
  end

endmodule
